@@ rtl/core/counter_sample_statistics_assert.svh @@
// Assertion macros for the counter statistics RTL.
`ifndef COUNTER_SAMPLE_STATISTICS_ASSERT_SVH
`define COUNTER_SAMPLE_STATISTICS_ASSERT_SVH

// Same-cycle implication, checked on the rising clock, off in reset.
`define CSS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/css_pkg.sv @@
package css_pkg;

   localparam int MAX_ITEMS     = 16;
   localparam int MAX_COLUMNS   = 16;
   localparam int COUNT_WIDTH   = 48;
   localparam int FRACTION_BITS = 8;
   localparam int STAT_WIDTH    = 56;
   localparam int ITEM_WIDTH    = 4;
   localparam int COLUMN_WIDTH  = 4;
   localparam int ENTRY_WIDTH   = ITEM_WIDTH + COLUMN_WIDTH;
   localparam int ENTRIES       = MAX_ITEMS * MAX_COLUMNS;
   localparam int SCOUNT_WIDTH  = 16;
   localparam int DIV_WIDTH     = 72;
   localparam int DVS_WIDTH     = 17;
   localparam int CSR_IDX_WIDTH = 4;
   localparam int CSR_WIDTH     = 32;

   // status codes
   localparam logic [1:0] ST_FIRST     = 2'd0;
   localparam logic [1:0] ST_COMPUTED  = 2'd1;
   localparam logic [1:0] ST_BACKWARDS = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   // column modes
   localparam logic [1:0] MODE_RAW  = 2'd0;
   localparam logic [1:0] MODE_DIFF = 2'd1;
   localparam logic [1:0] MODE_RATE = 2'd2;
   localparam logic [1:0] MODE_RAW3 = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLUMN_COUNT = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLUMN_MODES = 4'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INTERVAL     = 4'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TAIL_ENABLE  = 4'd3;

   localparam logic [4:0]  COLUMN_COUNT_RESET = 5'd16;
   localparam logic [15:0] INTERVAL_RESET     = 16'd60;

   typedef logic [STAT_WIDTH-1:0] stat_type;

   function automatic stat_type sat_stat(input logic [DIV_WIDTH-1:0] v);
      sat_stat = (|v[DIV_WIDTH-1:STAT_WIDTH]) ? {STAT_WIDTH{1'b1}} : v[STAT_WIDTH-1:0];
   endfunction

   // a above b by more than one tenth: 10*(a-b) > 2^FRACTION_BITS
   function automatic logic beyond_tenth(input stat_type a, input stat_type b);
      logic [STAT_WIDTH+3:0] d;
      logic [STAT_WIDTH+3:0] d10;
      d   = {4'd0, a - b};
      d10 = (d << 3) + (d << 1);
      beyond_tenth = (a > b) && (d10 > (STAT_WIDTH + 4)'(1 << FRACTION_BITS));
   endfunction

endpackage

@@ rtl/core/css_if.sv @@
interface css_req_if;
   import css_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [ITEM_WIDTH-1:0]    item_index;
   logic [COLUMN_WIDTH-1:0]  column_index;
   logic [COUNT_WIDTH-1:0]   current_count;
   modport source (output valid, item_index, column_index, current_count, input ready);
   modport sink   (input valid, item_index, column_index, current_count, output ready);
endinterface

interface css_rsp_if;
   import css_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [STAT_WIDTH-1:0] stat_value;
   logic [STAT_WIDTH-1:0] max_value;
   logic [STAT_WIDTH-1:0] min_value;
   logic [STAT_WIDTH-1:0] mean_value;
   modport source (output valid, status, stat_value, max_value, min_value, mean_value,
                   input ready);
   modport sink   (input valid, status, stat_value, max_value, min_value, mean_value,
                   output ready);
endinterface

interface css_csr_if;
   import css_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [CSR_WIDTH-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/css_div.sv @@
// Restoring divider, one quotient bit per cycle.
module css_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [css_pkg::DIV_WIDTH-1:0]     dividend,
   input  logic [css_pkg::DVS_WIDTH-1:0]     divisor,
   output logic                              busy,
   output logic                              done,
   output logic [css_pkg::DIV_WIDTH-1:0]     quotient
);
   import css_pkg::*;

   localparam int STEP_WIDTH = $clog2(DIV_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [DVS_WIDTH-1:0]   rem_ff, rem_in;
   logic [DVS_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [DIV_WIDTH-1:0]   quo_ff, quo_in;
   logic [DVS_WIDTH:0]     trial;
   logic                   ge;

   assign trial = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = STEP_WIDTH'(DIV_WIDTH);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = ge ? DVS_WIDTH'(trial - {1'b0, dvs_ff}) : trial[DVS_WIDTH-1:0];
         quo_in  = {quo_ff[DIV_WIDTH-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/counter_sample_statistics.sv @@
// Counter sample statistics: one request carries a counter sample for an entry
// (item, column). The block answers with one response holding a status, the
// entry's statistic and, with tail tracking on, its running max, min and mean
// (Q48.8). From the accept edge until the response is registered, a request
// passes through these sequencer states:
//   - out-of-range request: S_FIN only
//   - first sample: S_READ, S_EVAL, S_FIN
//   - computed or backwards, raw/diff, tail off: S_READ, S_EVAL, S_TAIL, S_FIN
// Per-interval mode adds the S_RATE state, one pass through the shared
// restoring divider. Each tail update after the first adds the S_MUL state,
// which starts the divider on the registered product, and another divider
// pass in S_MEAN for the mean. The divider produces one quotient bit a cycle
// over a 72-bit dividend.
// The request side is ready only while the sequencer is idle. A finished
// response sits in an output register, so the next request is taken while it
// waits. After reset a clearing pass over all entries zeroes the last-statistic
// and sample-count stores, and the request side stays not ready until it ends.
// Previous-valid is held in one flop per entry.
`include "counter_sample_statistics_assert.svh"

module counter_sample_statistics (
   input  logic     clock,
   input  logic     reset,
   css_req_if.sink  req_bus,
   css_rsp_if.source rsp_bus,
   css_csr_if.sink  csr_bus
);
   import css_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_RATE = 3'd3;
   localparam logic [2:0] S_TAIL = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_MEAN = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   // configuration registers
   logic [4:0]              column_count_ff;
   logic [31:0]             column_modes_ff;
   logic [15:0]             interval_ff;
   logic                    tail_enable_ff;

   // per-entry previous-valid flags
   logic [ENTRIES-1:0]      prev_vld_ff, prev_vld_in;

   // clearing pass after reset
   logic                    clr_busy_ff, clr_busy_in;
   logic [ENTRY_WIDTH-1:0]  clr_addr_ff, clr_addr_in;

   // entry stores
   logic [COUNT_WIDTH-1:0]  prev_mem [ENTRIES];
   stat_type                last_mem [ENTRIES];
   stat_type                max_mem  [ENTRIES];
   stat_type                min_mem  [ENTRIES];
   stat_type                mean_mem [ENTRIES];
   logic [SCOUNT_WIDTH-1:0] cnt_mem  [ENTRIES];

   logic [COUNT_WIDTH-1:0]  prev_q;
   stat_type                last_q, max_q, min_q, mean_q;
   logic [SCOUNT_WIDTH-1:0] cnt_q;

   // sequencer and working registers
   logic [2:0]              state_ff, state_in;
   logic [ENTRY_WIDTH-1:0]  addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0]  cur_ff, cur_in;
   logic [1:0]              mode_ff, mode_in;
   logic [1:0]              status_ff, status_in;
   stat_type                st_ff, st_in;
   stat_type                max_ff, max_in;
   stat_type                min_ff, min_in;
   stat_type                mean_ff, mean_in;
   logic [SCOUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIV_WIDTH-1:0]    prod_ff, prod_in;
   logic                    wr_last_ff, wr_last_in;
   logic                    wr_tail_ff, wr_tail_in;
   logic                    wr_prev_ff, wr_prev_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   stat_type                rsp_stat_ff, rsp_stat_in;
   stat_type                rsp_max_ff, rsp_max_in;
   stat_type                rsp_min_ff, rsp_min_in;
   stat_type                rsp_mean_ff, rsp_mean_in;

   // shared divider
   logic                    div_start;
   logic [DIV_WIDTH-1:0]    div_dividend;
   logic [DVS_WIDTH-1:0]    div_divisor;
   logic                    div_busy;
   logic                    div_done;
   logic [DIV_WIDTH-1:0]    div_quotient;

   logic                    req_xfer;
   logic                    rsp_free;
   logic                    fin_go;
   logic [4:0]              cols_used;
   logic                    in_range;
   logic                    diff_mode;
   logic [COUNT_WIDTH-1:0]  delta;
   stat_type                last_rd;
   logic [SCOUNT_WIDTH-1:0] cnt_rd;
   logic [DVS_WIDTH-1:0]    interval_div;

   css_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---- configuration port: always ready; the user must change config only while idle (not enforced)
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         column_modes_ff <= '0;
         interval_ff     <= INTERVAL_RESET;
         tail_enable_ff  <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_bus.data[4:0];
            CSR_COLUMN_MODES: column_modes_ff <= csr_bus.data;
            CSR_INTERVAL:     interval_ff     <= csr_bus.data[15:0];
            CSR_TAIL_ENABLE:  tail_enable_ff  <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // ---- clearing pass: one entry per cycle, all entries once
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---- handshakes
   assign req_bus.ready = (state_ff == S_IDLE) && !clr_busy_ff;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fin_go        = (state_ff == S_FIN) && rsp_free;

   assign cols_used = (column_count_ff > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : column_count_ff;
   assign in_range  = ({1'b0, req_bus.item_index} < 5'(MAX_ITEMS)) &&
                      ({1'b0, req_bus.column_index} < cols_used);

   // ---- entry reads, registered; address is stable from S_READ on
   always_ff @(posedge clock) begin
      prev_q <= prev_mem[addr_ff];
      last_q <= last_mem[addr_ff];
      max_q  <= max_mem[addr_ff];
      min_q  <= min_mem[addr_ff];
      mean_q <= mean_mem[addr_ff];
      cnt_q  <= cnt_mem[addr_ff];
   end

   // ---- entry writes: clearing pass, then at the end of a request
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         last_mem[clr_addr_ff] <= '0;
         cnt_mem[clr_addr_ff]  <= '0;
      end else if (fin_go) begin
         if (wr_prev_ff) begin
            prev_mem[addr_ff] <= cur_ff;
         end
         if (wr_last_ff) begin
            last_mem[addr_ff] <= st_ff;
         end
         if (wr_tail_ff) begin
            max_mem[addr_ff]  <= max_ff;
            min_mem[addr_ff]  <= min_ff;
            mean_mem[addr_ff] <= mean_ff;
            cnt_mem[addr_ff]  <= cnt_ff;
         end
      end
   end

   assign last_rd      = last_q;
   assign cnt_rd       = cnt_q;
   assign diff_mode    = (mode_ff == MODE_DIFF) || (mode_ff == MODE_RATE);
   assign delta        = cur_ff - prev_q;
   assign interval_div = (interval_ff == '0) ? DVS_WIDTH'(1) : {1'b0, interval_ff};

   // divider operands: per-interval rate from S_EVAL, mean from S_MUL
   always_comb begin
      div_start    = 1'b0;
      div_dividend = prod_ff + {{(DIV_WIDTH-STAT_WIDTH){1'b0}}, st_ff};
      div_divisor  = {1'b0, cnt_ff} + 1'b1;
      if (state_ff == S_EVAL) begin
         div_dividend = {{(DIV_WIDTH-STAT_WIDTH){1'b0}}, delta, {FRACTION_BITS{1'b0}}};
         div_divisor  = interval_div;
         div_start    = prev_vld_ff[addr_ff] && (mode_ff == MODE_RATE) && !(cur_ff < prev_q);
      end else if (state_ff == S_MUL) begin
         div_start    = 1'b1;
      end
   end

   // ---- sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      cur_in        = cur_ff;
      mode_in       = mode_ff;
      status_in     = status_ff;
      st_in         = st_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      mean_in       = mean_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      wr_prev_in    = wr_prev_ff;
      wr_last_in    = wr_last_ff;
      wr_tail_in    = wr_tail_ff;
      prev_vld_in   = prev_vld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_mean_in   = rsp_mean_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               addr_in    = {req_bus.item_index, req_bus.column_index};
               cur_in     = req_bus.current_count;
               mode_in    = column_modes_ff[{req_bus.column_index, 1'b0} +: 2];
               wr_prev_in = 1'b0;
               wr_last_in = 1'b0;
               wr_tail_in = 1'b0;
               if (in_range) begin
                  state_in = S_READ;
               end else begin
                  // out of range: all-zero result, nothing stored
                  status_in = ST_RANGE;
                  st_in     = '0;
                  cnt_in    = '0;
                  state_in  = S_FIN;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            max_in     = max_q;
            min_in     = min_q;
            mean_in    = mean_q;
            cnt_in     = cnt_rd;
            st_in      = last_rd;
            wr_prev_in = 1'b1;
            if (!prev_vld_ff[addr_ff]) begin
               status_in = ST_FIRST;
               state_in  = S_FIN;
            end else if (diff_mode && (cur_ff < prev_q)) begin
               status_in = ST_BACKWARDS;
               state_in  = S_TAIL;
            end else begin
               status_in  = ST_COMPUTED;
               wr_last_in = 1'b1;
               if (mode_ff == MODE_RATE) begin
                  state_in = S_RATE;
               end else if (mode_ff == MODE_DIFF) begin
                  st_in    = {delta, {FRACTION_BITS{1'b0}}};
                  state_in = S_TAIL;
               end else begin
                  st_in    = {cur_ff, {FRACTION_BITS{1'b0}}};
                  state_in = S_TAIL;
               end
            end
         end
         S_RATE: begin
            if (div_done) begin
               st_in    = sat_stat(div_quotient);
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (!tail_enable_ff) begin
               state_in = S_FIN;
            end else if (cnt_ff == '0) begin
               wr_tail_in = 1'b1;
               max_in     = st_ff;
               min_in     = st_ff;
               mean_in    = st_ff;
               cnt_in     = SCOUNT_WIDTH'(1);
               state_in   = S_FIN;
            end else begin
               if (beyond_tenth(st_ff, max_ff)) begin
                  max_in = st_ff;
               end
               if (beyond_tenth(min_ff, st_ff)) begin
                  min_in = st_ff;
               end
               // full 72-bit product of mean and sample count
               prod_in  = {{(DIV_WIDTH-STAT_WIDTH){1'b0}}, mean_ff} *
                          {{(DIV_WIDTH-SCOUNT_WIDTH){1'b0}}, cnt_ff};
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_MEAN;
         end
         S_MEAN: begin
            if (div_done) begin
               wr_tail_in = 1'b1;
               mean_in    = sat_stat(div_quotient);
               if (cnt_ff != {SCOUNT_WIDTH{1'b1}}) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_stat_in   = st_ff;
               if (tail_enable_ff && (cnt_ff != '0) && (status_ff != ST_RANGE)) begin
                  rsp_max_in  = max_ff;
                  rsp_min_in  = min_ff;
                  rsp_mean_in = mean_ff;
               end else begin
                  rsp_max_in  = '0;
                  rsp_min_in  = '0;
                  rsp_mean_in = '0;
               end
               if (wr_prev_ff) begin
                  prev_vld_in[addr_ff] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_vld_ff  <= '0;
         wr_prev_ff   <= 1'b0;
         wr_last_ff   <= 1'b0;
         wr_tail_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_vld_ff  <= prev_vld_in;
         wr_prev_ff   <= wr_prev_in;
         wr_last_ff   <= wr_last_in;
         wr_tail_ff   <= wr_tail_in;
      end
      addr_ff       <= addr_in;
      cur_ff        <= cur_in;
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      st_ff         <= st_in;
      max_ff        <= max_in;
      min_ff        <= min_in;
      mean_ff       <= mean_in;
      cnt_ff        <= cnt_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_stat_ff   <= rsp_stat_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_mean_ff   <= rsp_mean_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.stat_value = rsp_stat_ff;
   assign rsp_bus.max_value  = rsp_max_ff;
   assign rsp_bus.min_value  = rsp_min_ff;
   assign rsp_bus.mean_value = rsp_mean_ff;

   // ---- checks
   `CSS_ASSERT_NEXT(a_req_leaves_idle, req_xfer, state_ff != S_IDLE, "request taken but sequencer idle")
   `CSS_ASSERT_NEXT(a_fin_loads_rsp, fin_go, rsp_valid_ff, "finished request produced no response")
   `CSS_ASSERT_NOW(a_range_zero, rsp_valid_ff && (rsp_status_ff == ST_RANGE), (rsp_stat_ff == '0) && (rsp_max_ff == '0) && (rsp_mean_ff == '0), "out-of-range response not zero")
   `CSS_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")

endmodule

@@ bench/css_tb_if.sv @@
`timescale 1ns / 1ps

// Stimulus-side handle for the three bus interfaces is the RTL's own css_if.sv;
// this file carries the bench's expected-result struct type.
package css_tb_pkg;
   import css_pkg::*;

   typedef struct packed {
      logic [1:0]            status;
      logic [STAT_WIDTH-1:0] stat_value;
      logic [STAT_WIDTH-1:0] max_value;
      logic [STAT_WIDTH-1:0] min_value;
      logic [STAT_WIDTH-1:0] mean_value;
   } stat_result_type;
endpackage

@@ bench/css_checker.sv @@
`timescale 1ns / 1ps

module css_checker (
   input  logic         clock,
   input  logic         reset,
   css_req_if           req_bus,
   css_rsp_if           rsp_bus,
   css_csr_if           csr_bus,
   output int           fail_count,
   output int           pending
);
   import css_pkg::*;
   import css_tb_pkg::*;

   logic [4:0]  col_count_q;
   logic [31:0] modes_q;
   logic [15:0] interval_q;
   logic        tail_q;

   logic [COUNT_WIDTH-1:0] prev_cnt [ENTRIES];
   logic                   prev_ok  [ENTRIES];
   stat_type               last_s   [ENTRIES];
   stat_type               max_s    [ENTRIES];
   stat_type               min_s    [ENTRIES];
   stat_type               mean_s   [ENTRIES];
   logic [15:0]            nsamp    [ENTRIES];

   stat_result_type stats_due [$];

   function automatic stat_type clip56(logic [71:0] v);
      return (v > 72'h00FFFFFFFFFFFFFF) ? '1 : v[55:0];
   endfunction

   function automatic logic above_tenth(stat_type a, stat_type b);
      logic [71:0] d;
      d = a - b;
      return (a > b) && (d * 10 > (72'd1 << FRACTION_BITS));
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   task automatic predict_stat(logic [3:0] item, logic [3:0] col, logic [47:0] cur);
      stat_result_type r;
      int          e;
      logic [4:0]  cols;
      logic [1:0]  mode;
      logic [71:0] s;
      logic [71:0] acc;
      logic [15:0] n;
      r = '0;
      cols = (col_count_q > 16) ? 5'd16 : col_count_q;
      if ({1'b0, col} >= cols) begin
         r.status = ST_RANGE;
         stats_due.push_back(r);
         return;
      end
      e = item * MAX_COLUMNS + col;
      mode = modes_q[2*col +: 2];
      if (!prev_ok[e]) begin
         prev_ok[e] = 1'b1;
         prev_cnt[e] = cur;
         r.status = ST_FIRST;
      end else begin
         if ((mode == MODE_DIFF || mode == MODE_RATE) && cur < prev_cnt[e]) begin
            r.status = ST_BACKWARDS;
         end else begin
            r.status = ST_COMPUTED;
            if (mode == MODE_DIFF || mode == MODE_RATE) begin
               s = 72'(cur - prev_cnt[e]) << FRACTION_BITS;
               if (mode == MODE_RATE)
                  s = s / ((interval_q == 0) ? 72'd1 : 72'(interval_q));
            end else begin
               s = 72'(cur) << FRACTION_BITS;
            end
            last_s[e] = clip56(s);
         end
         prev_cnt[e] = cur;
         if (tail_q) begin
            n = nsamp[e];
            if (n == 0) begin
               max_s[e] = last_s[e];
               min_s[e] = last_s[e];
               mean_s[e] = last_s[e];
            end else begin
               if (above_tenth(last_s[e], max_s[e])) max_s[e] = last_s[e];
               if (above_tenth(min_s[e], last_s[e])) min_s[e] = last_s[e];
               acc = 72'(mean_s[e]) * n + last_s[e];
               mean_s[e] = clip56(acc / (72'(n) + 1));
            end
            if (n != 16'hFFFF) nsamp[e] = n + 16'd1;
         end
      end
      r.stat_value = last_s[e];
      if (tail_q && nsamp[e] != 0) begin
         r.max_value = max_s[e];
         r.min_value = min_s[e];
         r.mean_value = mean_s[e];
      end
      stats_due.push_back(r);
   endtask

   always @(posedge clock) begin
      stat_result_type w;
      if (reset) begin
         col_count_q <= COLUMN_COUNT_RESET;
         modes_q <= '0;
         interval_q <= INTERVAL_RESET;
         tail_q <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            prev_ok[i] = 1'b0; prev_cnt[i] = '0; last_s[i] = '0;
            max_s[i] = '0; min_s[i] = '0; mean_s[i] = '0; nsamp[i] = '0;
         end
         stats_due.delete();
         fail_count = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_COLUMN_COUNT: col_count_q <= csr_bus.data[4:0];
               CSR_COLUMN_MODES: modes_q <= csr_bus.data;
               CSR_INTERVAL:     interval_q <= csr_bus.data[15:0];
               CSR_TAIL_ENABLE:  tail_q <= csr_bus.data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            predict_stat(req_bus.item_index, req_bus.column_index, req_bus.current_count);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (stats_due.size() == 0) begin
               report("unexpected transfer", rsp_bus.status, 0);
            end else begin
               w = stats_due.pop_front();
               if (rsp_bus.status !== w.status) report("status", rsp_bus.status, w.status);
               if (rsp_bus.stat_value !== w.stat_value)
                  report("stat", rsp_bus.stat_value, w.stat_value);
               if (rsp_bus.max_value !== w.max_value)
                  report("max", rsp_bus.max_value, w.max_value);
               if (rsp_bus.min_value !== w.min_value)
                  report("min", rsp_bus.min_value, w.min_value);
               if (rsp_bus.mean_value !== w.mean_value)
                  report("mean", rsp_bus.mean_value, w.mean_value);
            end
         end
      end
      pending = stats_due.size();
   end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import css_pkg::*;

   // index with no register behind it
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED = 4'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   send_idle;   // percent of cycles the sender skips
   int   recv_stall;  // percent of cycles the receiver stalls
   bit   hold_rsp;    // long receiver hold-off in progress
   bit   stim_done;

   css_req_if req_bus();
   css_rsp_if rsp_bus();
   css_csr_if csr_bus();

   always #1 clock = ~clock;

   counter_sample_statistics u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   css_checker u_chk (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_bus   (csr_bus),
      .fail_count(fail_count),
      .pending   (pending)
   );

   // last count sent per entry, so random steps start from the entry's previous sample
   logic [47:0] last_cnt [16][16];

   // response side: random stalls, plus the long hold-off when asked
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !reset && !hold_rsp && ($urandom_range(99) >= recv_stall);
      end
   end

   // valid stays high after a transfer; idle gaps and drain() drop it
   task automatic send_sample(logic [3:0] item, logic [3:0] col, logic [47:0] cnt);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.item_index <= item;
      req_bus.column_index <= col;
      req_bus.current_count <= cnt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      last_cnt[item][col] = cnt;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock); // margin for the deepest request to finish
   endtask

   // idle-only register write
   task automatic write_reg(logic [3:0] idx, logic [31:0] val);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // mostly moves the counter forward by a small or large step, sometimes back
   function automatic logic [47:0] next_count(logic [47:0] old);
      case ($urandom_range(9))
         0: return 48'({$urandom, $urandom});
         1: return old - $urandom_range(1000);
         2: return 48'hFFFF_FFFF_FFFF;
         3: return old;
         4: return old + 48'({$urandom, $urandom});
         default: return old + $urandom_range(5000);
      endcase
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      logic [3:0] it, cl;
      send_idle = idle;
      recv_stall = stall;
      repeat (n) begin
         it = 4'($urandom_range(15));
         cl = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
         send_sample(it, cl, next_count(last_cnt[it][cl]));
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.item_index = '0;
      req_bus.column_index = '0;
      req_bus.current_count = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      send_idle = 0;
      recv_stall = 0;
      hold_rsp = 1'b0;
      stim_done = 1'b0;
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 16; j++) last_cnt[i][j] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset config, raw mode, first sample, extremes
      send_sample(4'd0, 4'd0, 48'd0);
      send_sample(4'd0, 4'd0, 48'hFFFF_FFFF_FFFF);
      send_sample(4'd15, 4'd15, 48'hFFFF_FFFF_FFFF);
      send_sample(4'd15, 4'd15, 48'd0);
      // modes: col1 diff, col2 rate, col3 raw3; tail on
      write_reg(CSR_COLUMN_MODES, 32'b11_10_01_00);
      write_reg(CSR_TAIL_ENABLE, 32'd1);
      write_reg(CSR_INTERVAL, 32'd0);  // interval zero acts as one
      send_sample(4'd1, 4'd1, 48'd100);
      send_sample(4'd1, 4'd1, 48'd300);
      send_sample(4'd1, 4'd1, 48'd50);   // counter went backwards
      send_sample(4'd1, 4'd1, 48'd60);
      send_sample(4'd1, 4'd2, 48'd0);
      send_sample(4'd1, 4'd2, 48'hFFFF_FFFF_FFFF);
      send_sample(4'd1, 4'd3, 48'd5);
      send_sample(4'd1, 4'd3, 48'd7);
      write_reg(CSR_INTERVAL, 32'd65535);
      send_sample(4'd1, 4'd2, 48'hFFFF_FFFF_FFFF);
      send_sample(4'd1, 4'd2, 48'd0);
      write_reg(CSR_TAIL_ENABLE, 32'd0); // tail frozen
      send_sample(4'd1, 4'd1, 48'd90);
      write_reg(CSR_TAIL_ENABLE, 32'd1);
      send_sample(4'd1, 4'd1, 48'd99);
      write_reg(CSR_COLUMN_COUNT, 32'd1);
      send_sample(4'd2, 4'd1, 48'd1);    // column out of range
      write_reg(CSR_COLUMN_COUNT, 32'd31); // above limit acts as 16
      send_sample(4'd2, 4'd15, 48'd1);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);    // unknown index, ignored
      write_reg(CSR_INTERVAL, 32'd60);

      random_phase(400, 0, 0);
      write_reg(CSR_COLUMN_MODES, $urandom);
      write_reg(CSR_INTERVAL, $urandom_range(65535, 1));
      random_phase(350, 76, 0);
      write_reg(CSR_COLUMN_COUNT, $urandom_range(8, 1));
      write_reg(CSR_TAIL_ENABLE, 32'd0);
      random_phase(300, 0, 76);
      write_reg(CSR_COLUMN_COUNT, 32'd16);
      write_reg(CSR_COLUMN_MODES, 32'hAAAA_AAAA);
      write_reg(CSR_INTERVAL, 32'd1);
      write_reg(CSR_TAIL_ENABLE, 32'd1);
      random_phase(350, 19, 19);

      // long hold-off on the response side while requests keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (800) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_phase(20, 0, 0);
      join
      // sender pause until every expected transfer has come
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      write_reg(CSR_COLUMN_MODES, 32'h5555_5555);
      random_phase(420, 0, 0);
      drain();
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end
endmodule
